/* rtl/core/tsm_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package tsm_pkg;

    // configuration register indexes
    localparam logic [1:0] CFG_REJECT_X = 2'd0;
    localparam logic [1:0] CFG_REJECT_Y = 2'd1;
    localparam logic [1:0] CFG_COUNT    = 2'd2;

    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 12;
    localparam int CFG_REJECT_W  = 12;
    localparam int CFG_COUNT_W   = 5;

    localparam logic [CFG_REJECT_W-1:0] REJECT_RESET = 12'd16;
    localparam logic [CFG_COUNT_W-1:0]  COUNT_RESET  = 5'd4;

    // above this count the extremes are dropped; the divisor shrinks by TRIM_DROP
    localparam int TRIM_MIN_COUNT = 3;
    localparam int TRIM_DROP      = 2;

    localparam int POS_BITS    = 12;
    localparam int OUT_TDATA_W = 16;
    localparam int TUSER_W     = 2;

    // tuser bit positions
    localparam int TUSER_AXIS    = 0;
    localparam int TUSER_RESTART = 1;
    localparam int TUSER_REJECT  = 1;

    typedef enum logic [1:0] {
        PH_DISCARD,
        PH_CHECK1,
        PH_CHECK2,
        PH_ACCUM
    } t_phase;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_TRIM,
        BK_DIV,
        BK_DONE
    } t_back_state;

    typedef struct packed {
        logic axis;
        logic rejected;
    } t_job_ctl;

endpackage

`default_nettype wire

/* rtl/core/tsm_front.sv */
`timescale 1ns / 1ps
`default_nettype none

module tsm_front #(
    parameter int MAX_SAMPLES = 16,
    parameter int SAMPLE_BITS = 12,
    localparam int CW   = ($clog2(MAX_SAMPLES + 1) < 3) ? 3 : $clog2(MAX_SAMPLES + 1),
    localparam int SUMW = SAMPLE_BITS + CW
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_valid,
    output logic                               o_ready,
    input  wire  [SAMPLE_BITS-1:0]             i_sample,
    input  wire                                i_axis,
    input  wire                                i_restart,
    input  wire  [tsm_pkg::CFG_REJECT_W-1:0]   i_reject_x,
    input  wire  [tsm_pkg::CFG_REJECT_W-1:0]   i_reject_y,
    input  wire  [tsm_pkg::CFG_COUNT_W-1:0]    i_count,
    input  wire                                i_q_full,
    output logic                               o_push,
    output tsm_pkg::t_job_ctl                  o_job_ctl,
    output logic [SUMW-1:0]                    o_job_sum,
    output logic [SAMPLE_BITS-1:0]             o_job_min,
    output logic [SAMPLE_BITS-1:0]             o_job_max,
    output logic [CW-1:0]                      o_job_cnt
);

    localparam int EW = (CW > tsm_pkg::CFG_COUNT_W) ? CW : tsm_pkg::CFG_COUNT_W;
    localparam int GW = (SAMPLE_BITS > tsm_pkg::CFG_REJECT_W) ? SAMPLE_BITS
                                                               : tsm_pkg::CFG_REJECT_W;

    tsm_pkg::t_phase r_phase, n_phase;
    logic [CW-1:0]          r_taken;
    logic                   r_axis;
    logic [SAMPLE_BITS-1:0] r_check;
    logic [SUMW-1:0]        r_sum;
    logic [SAMPLE_BITS-1:0] r_min;
    logic [SAMPLE_BITS-1:0] r_max;

    logic                   accept;
    logic                   start;
    logic [EW-1:0]          cnt_ext;
    logic [CW-1:0]          eff_cnt;
    logic [CW-1:0]          taken_next;
    logic                   done;
    logic [SUMW-1:0]        sum_next;
    logic [SAMPLE_BITS-1:0] min_next;
    logic [SAMPLE_BITS-1:0] max_next;
    logic [SAMPLE_BITS-1:0] gap;
    logic [CW-1:0]          unused_lim;
    logic [tsm_pkg::CFG_REJECT_W-1:0] lim;
    logic                   too_far;

    assign o_ready = ~i_q_full;
    assign accept  = i_valid & ~i_q_full;
    assign start   = accept & (i_restart | (r_phase == tsm_pkg::PH_DISCARD));

    // zero count means one, oversize count clamps to the parameter
    always_comb begin
        cnt_ext = EW'(i_count);
        if (cnt_ext == '0) begin
            eff_cnt = CW'(1);
        end else if (cnt_ext > EW'(MAX_SAMPLES)) begin
            eff_cnt = CW'(MAX_SAMPLES);
        end else begin
            eff_cnt = cnt_ext[CW-1:0];
        end
    end

    assign unused_lim = '0;
    assign taken_next = r_taken + CW'(1) + unused_lim;
    assign done       = (taken_next >= eff_cnt);
    assign sum_next   = r_sum + SUMW'(i_sample);
    assign min_next   = (i_sample < r_min) ? i_sample : r_min;
    assign max_next   = (i_sample > r_max) ? i_sample : r_max;
    assign gap        = (r_check > i_sample) ? (r_check - i_sample) : (i_sample - r_check);
    assign lim        = r_axis ? i_reject_y : i_reject_x;
    assign too_far    = (GW'(gap) > GW'(lim));

    // next phase
    always_comb begin
        n_phase = r_phase;
        if (accept) begin
            if (i_restart) begin
                n_phase = tsm_pkg::PH_CHECK1;
            end else begin
                case (r_phase)
                    tsm_pkg::PH_DISCARD: n_phase = tsm_pkg::PH_CHECK1;
                    tsm_pkg::PH_CHECK1:  n_phase = tsm_pkg::PH_CHECK2;
                    tsm_pkg::PH_CHECK2: begin
                        n_phase = too_far ? tsm_pkg::PH_DISCARD : tsm_pkg::PH_ACCUM;
                    end
                    tsm_pkg::PH_ACCUM: begin
                        n_phase = done ? tsm_pkg::PH_DISCARD : tsm_pkg::PH_ACCUM;
                    end
                    default: n_phase = tsm_pkg::PH_DISCARD;
                endcase
            end
        end
    end

    // queue push and job contents
    always_comb begin
        o_push             = 1'b0;
        o_job_ctl.axis     = r_axis;
        o_job_ctl.rejected = 1'b0;
        case (r_phase)
            tsm_pkg::PH_CHECK2: begin
                o_push             = accept & ~i_restart & too_far;
                o_job_ctl.rejected = 1'b1;
            end
            tsm_pkg::PH_ACCUM: begin
                o_push = accept & ~i_restart & done;
            end
            default: o_push = 1'b0;
        endcase
    end

    assign o_job_sum = sum_next;
    assign o_job_min = min_next;
    assign o_job_max = max_next;
    assign o_job_cnt = eff_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= tsm_pkg::PH_DISCARD;
            r_taken <= '0;
            r_axis  <= 1'b0;
        end else begin
            r_phase <= n_phase;
            if (start) begin
                r_axis  <= i_axis;
                r_taken <= '0;
            end else if (accept && r_phase == tsm_pkg::PH_ACCUM) begin
                r_taken <= done ? '0 : taken_next;
            end
        end
    end

    // accumulator: cleared at every discarded sample and after each result
    always_ff @(posedge i_clk) begin
        if (start) begin
            r_sum <= '0;
            r_min <= '1;
            r_max <= '0;
        end else if (accept && r_phase == tsm_pkg::PH_CHECK1) begin
            r_check <= i_sample;
        end else if (accept && r_phase == tsm_pkg::PH_ACCUM) begin
            if (done) begin
                r_sum <= '0;
                r_min <= '1;
                r_max <= '0;
            end else begin
                r_sum <= sum_next;
                r_min <= min_next;
                r_max <= max_next;
            end
        end
    end

endmodule

`default_nettype wire

/* rtl/core/tsm_queue.sv */
`timescale 1ns / 1ps
`default_nettype none

module tsm_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4,
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int NW = $clog2(DEPTH + 1)
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_push,
    input  wire  [WIDTH-1:0] i_data,
    output logic             o_full,
    input  wire              i_pop,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr_ptr;
    logic [PW-1:0]    r_rd_ptr;
    logic [NW-1:0]    r_fill;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_fill == NW'(DEPTH));
    assign o_valid = (r_fill != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push & ~o_full;
    assign do_pop  = i_pop & o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
            end
            if (do_push && !do_pop) begin
                r_fill <= r_fill + NW'(1);
            end else if (do_pop && !do_push) begin
                r_fill <= r_fill - NW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

`default_nettype wire

/* rtl/core/tsm_back.sv */
`timescale 1ns / 1ps
`default_nettype none

module tsm_back #(
    parameter int MAX_SAMPLES = 16,
    parameter int SAMPLE_BITS = 12,
    localparam int CW   = ($clog2(MAX_SAMPLES + 1) < 3) ? 3 : $clog2(MAX_SAMPLES + 1),
    localparam int SUMW = SAMPLE_BITS + CW
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_q_valid,
    output logic                             o_q_pop,
    input  tsm_pkg::t_job_ctl                i_job_ctl,
    input  wire  [SUMW-1:0]                  i_job_sum,
    input  wire  [SAMPLE_BITS-1:0]           i_job_min,
    input  wire  [SAMPLE_BITS-1:0]           i_job_max,
    input  wire  [CW-1:0]                    i_job_cnt,
    output logic                             o_valid,
    input  wire                              i_ready,
    output logic                             o_axis,
    output logic                             o_rejected,
    output logic [tsm_pkg::POS_BITS-1:0]     o_position
);

    localparam int IW = $clog2(SUMW);
    localparam int QW = (SUMW > tsm_pkg::POS_BITS) ? SUMW : tsm_pkg::POS_BITS;

    tsm_pkg::t_back_state r_state, n_state;
    tsm_pkg::t_job_ctl      r_ctl;
    logic [SUMW-1:0]        r_sum;
    logic [SAMPLE_BITS-1:0] r_min;
    logic [SAMPLE_BITS-1:0] r_max;
    logic [CW-1:0]          r_cnt;
    logic [CW-1:0]          r_div;
    logic [CW-1:0]          r_rem;
    logic [SUMW-1:0]        r_work;     // dividend, then quotient
    logic [IW-1:0]          r_iter;

    logic [SUMW-1:0]        trimmed;
    logic                   do_trim;
    logic [CW:0]            trial;
    logic [CW:0]            diff;
    logic                   ge;
    logic [QW-1:0]          quot_ext;

    assign trimmed = r_sum - SUMW'(r_min) - SUMW'(r_max);
    assign do_trim = (r_cnt > CW'(tsm_pkg::TRIM_MIN_COUNT));
    assign trial   = {r_rem, r_work[SUMW-1]};
    assign diff    = trial - {1'b0, r_div};
    assign ge      = (trial >= {1'b0, r_div});

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            tsm_pkg::BK_IDLE: if (i_q_valid) n_state = tsm_pkg::BK_TRIM;
            tsm_pkg::BK_TRIM: n_state = r_ctl.rejected ? tsm_pkg::BK_DONE : tsm_pkg::BK_DIV;
            tsm_pkg::BK_DIV:  if (r_iter == '0) n_state = tsm_pkg::BK_DONE;
            tsm_pkg::BK_DONE: if (i_ready) n_state = tsm_pkg::BK_IDLE;
            default:          n_state = tsm_pkg::BK_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_q_pop = 1'b0;
        o_valid = 1'b0;
        case (r_state)
            tsm_pkg::BK_IDLE: o_q_pop = i_q_valid;
            tsm_pkg::BK_DONE: o_valid = 1'b1;
            default: begin
                o_q_pop = 1'b0;
                o_valid = 1'b0;
            end
        endcase
    end

    assign quot_ext   = QW'(r_work);
    assign o_position = quot_ext[tsm_pkg::POS_BITS-1:0];
    assign o_axis     = r_ctl.axis;
    assign o_rejected = r_ctl.rejected;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tsm_pkg::BK_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // datapath; restoring division over the whole dividend, one quotient bit
    // per cycle. A count lowered mid-run can leave a quotient wider than the
    // position, so all SUMW steps run and only the low bits go out.
    always_ff @(posedge i_clk) begin
        case (r_state)
            tsm_pkg::BK_IDLE: begin
                if (i_q_valid) begin
                    r_ctl <= i_job_ctl;
                    r_sum <= i_job_sum;
                    r_min <= i_job_min;
                    r_max <= i_job_max;
                    r_cnt <= i_job_cnt;
                end
            end
            tsm_pkg::BK_TRIM: begin
                r_iter <= IW'(SUMW - 1);
                r_rem  <= '0;
                if (r_ctl.rejected) begin
                    r_work <= '0;
                end else if (do_trim) begin
                    r_work <= trimmed;
                    r_div  <= r_cnt - CW'(tsm_pkg::TRIM_DROP);
                end else begin
                    r_work <= r_sum;
                    r_div  <= r_cnt;
                end
            end
            tsm_pkg::BK_DIV: begin
                r_rem  <= ge ? diff[CW-1:0] : trial[CW-1:0];
                r_work <= {r_work[SUMW-2:0], ge};
                r_iter <= r_iter - IW'(1);
            end
            default: begin
                r_iter <= r_iter;
            end
        endcase
    end

endmodule

`default_nettype wire

/* rtl/core/touch_sample_trimmed_mean_unit.sv */
// Flow: the sample that ends a measurement pushes a job into the queue; the back end pops
//   it in IDLE, steps through TRIM and DIV (DIV skipped for a rejection) and shows it in DONE.
// Throughput: one sample per cycle while the job queue has room; the back end takes one job
//   at a time in its bit-serial divider and pops the next only after the current result is taken.
// Reset: synchronous active-low; configuration returns to its defaults, the
//   queue empties and the next sample starts a measurement as the discarded one.
`timescale 1ns / 1ps
`default_nettype none

module touch_sample_trimmed_mean_unit #(
    parameter int MAX_SAMPLES = 16,
    parameter int SAMPLE_BITS = 12,
    parameter int QUEUE_DEPTH = 4,
    localparam int IN_TDATA_W = ((SAMPLE_BITS + 7) / 8) * 8
) (
    input  wire                               i_clk,
    input  wire                               i_rst_n,

    // sample stream in
    input  wire                               i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    input  wire  [IN_TDATA_W-1:0]             i_s_axis_tdata,  // [SAMPLE_BITS-1:0] sample
    input  wire  [tsm_pkg::TUSER_W-1:0]       i_s_axis_tuser,  // [0] axis, [1] restart

    // result stream out
    output logic                              o_m_axis_tvalid,
    input  wire                               i_m_axis_tready,
    output logic [tsm_pkg::OUT_TDATA_W-1:0]   o_m_axis_tdata,  // [11:0] position
    output logic [tsm_pkg::TUSER_W-1:0]       o_m_axis_tuser,  // [0] axis_out, [1] rejected

    // configuration writes
    input  wire                               i_cfg_we,
    input  wire  [tsm_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire  [tsm_pkg::CFG_DATA_W-1:0]    i_cfg_wdata
);

    localparam int CW    = ($clog2(MAX_SAMPLES + 1) < 3) ? 3 : $clog2(MAX_SAMPLES + 1);
    localparam int SUMW  = SAMPLE_BITS + CW;
    localparam int JOB_W = $bits(tsm_pkg::t_job_ctl) + SUMW + 2 * SAMPLE_BITS + CW;

    // configuration registers
    logic [tsm_pkg::CFG_REJECT_W-1:0] r_reject_x;
    logic [tsm_pkg::CFG_REJECT_W-1:0] r_reject_y;
    logic [tsm_pkg::CFG_COUNT_W-1:0]  r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reject_x <= tsm_pkg::REJECT_RESET;
            r_reject_y <= tsm_pkg::REJECT_RESET;
            r_count    <= tsm_pkg::COUNT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                tsm_pkg::CFG_REJECT_X: r_reject_x <= i_cfg_wdata[tsm_pkg::CFG_REJECT_W-1:0];
                tsm_pkg::CFG_REJECT_Y: r_reject_y <= i_cfg_wdata[tsm_pkg::CFG_REJECT_W-1:0];
                tsm_pkg::CFG_COUNT:    r_count    <= i_cfg_wdata[tsm_pkg::CFG_COUNT_W-1:0];
                default:               r_count    <= r_count;   // unmapped index, dropped
            endcase
        end
    end

    // front end: tracks the measurement phase, accumulates sum/min/max and
    // pushes one job per finished or rejected measurement
    logic                    push;
    logic                    q_full;
    tsm_pkg::t_job_ctl       f_ctl;
    logic [SUMW-1:0]         f_sum;
    logic [SAMPLE_BITS-1:0]  f_min;
    logic [SAMPLE_BITS-1:0]  f_max;
    logic [CW-1:0]           f_cnt;

    tsm_front #(
        .MAX_SAMPLES (MAX_SAMPLES),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_s_axis_tvalid),
        .o_ready    (o_s_axis_tready),
        .i_sample   (i_s_axis_tdata[SAMPLE_BITS-1:0]),
        .i_axis     (i_s_axis_tuser[tsm_pkg::TUSER_AXIS]),
        .i_restart  (i_s_axis_tuser[tsm_pkg::TUSER_RESTART]),
        .i_reject_x (r_reject_x),
        .i_reject_y (r_reject_y),
        .i_count    (r_count),
        .i_q_full   (q_full),
        .o_push     (push),
        .o_job_ctl  (f_ctl),
        .o_job_sum  (f_sum),
        .o_job_min  (f_min),
        .o_job_max  (f_max),
        .o_job_cnt  (f_cnt)
    );

    // job queue decouples sample intake from the divider
    logic                    q_valid;
    logic                    q_pop;
    logic [JOB_W-1:0]        q_data;
    tsm_pkg::t_job_ctl       b_ctl;
    logic [SUMW-1:0]         b_sum;
    logic [SAMPLE_BITS-1:0]  b_min;
    logic [SAMPLE_BITS-1:0]  b_max;
    logic [CW-1:0]           b_cnt;

    tsm_queue #(
        .WIDTH (JOB_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  ({f_ctl, f_sum, f_min, f_max, f_cnt}),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_data)
    );

    assign {b_ctl, b_sum, b_min, b_max, b_cnt} = q_data;

    // back end: trims extremes above the trim count, divides unless rejected, holds the result until taken
    logic                          r_unused;
    logic                          res_axis;
    logic                          res_rej;
    logic [tsm_pkg::POS_BITS-1:0]  res_pos;

    tsm_back #(
        .MAX_SAMPLES (MAX_SAMPLES),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_valid  (q_valid),
        .o_q_pop    (q_pop),
        .i_job_ctl  (b_ctl),
        .i_job_sum  (b_sum),
        .i_job_min  (b_min),
        .i_job_max  (b_max),
        .i_job_cnt  (b_cnt),
        .o_valid    (o_m_axis_tvalid),
        .i_ready    (i_m_axis_tready),
        .o_axis     (res_axis),
        .o_rejected (res_rej),
        .o_position (res_pos)
    );

    assign r_unused       = 1'b0;
    assign o_m_axis_tdata = {{(tsm_pkg::OUT_TDATA_W - tsm_pkg::POS_BITS){r_unused}}, res_pos};
    assign o_m_axis_tuser = {res_rej, res_axis};

endmodule

`default_nettype wire

/* rtl/core/tsm_checker.sv */
`timescale 1ns / 1ps
`default_nettype none

module tsm_checker (
    input wire                             i_clk,
    input wire                             i_rst_n,
    input wire                             o_m_axis_tvalid,
    input wire                             i_m_axis_tready,
    input wire [tsm_pkg::OUT_TDATA_W-1:0]  o_m_axis_tdata,
    input wire [tsm_pkg::TUSER_W-1:0]      o_m_axis_tuser
);

    // a measurement needs at least three samples, so no result can be shown
    // while the first samples after reset are still coming in
    a_quiet_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid ##1 !o_m_axis_tvalid ##1 !o_m_axis_tvalid)
        else $error("result shown too soon after reset");

    // a stalled result holds
    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))
        else $error("stalled result changed");

    // a rejected measurement carries a zero position
    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser[tsm_pkg::TUSER_REJECT] |->
            o_m_axis_tdata == '0)
        else $error("rejected result with nonzero position");

    // the back end returns to IDLE after each result, so results never leave back to back
    a_no_back_to_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && i_m_axis_tready |=> !o_m_axis_tvalid)
        else $error("results closer than the back end allows");

endmodule

bind touch_sample_trimmed_mean_unit tsm_checker u_tsm_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser)
);

`default_nettype wire

/* test/touch_sample_trimmed_mean_unit_test.sv */
`timescale 1ns / 1ps

module touch_sample_trimmed_mean_unit_test;

    // Samples go in on the slave stream. An internal predictor tracks the
    // measurement state: the discarded sample, the two check samples, then the
    // accumulate run with min/max tracking. Each accepted input transaction
    // advances that predictor, and every result it makes is queued. Results on
    // the master stream are popped and compared field by field. Both streams
    // idle and stall at random, with some stretches run at full rate.

    localparam int IN_W         = 16;     // sample padded to whole bytes
    localparam int POS_W        = tsm_pkg::POS_BITS;
    localparam int REJ_W        = tsm_pkg::CFG_REJECT_W;
    localparam int CNT_W        = tsm_pkg::CFG_COUNT_W;
    localparam int DAT_W        = tsm_pkg::CFG_DATA_W;
    localparam int IDX_W        = tsm_pkg::CFG_IDX_W;
    localparam int USR_W        = tsm_pkg::TUSER_W;
    localparam int OUT_W        = tsm_pkg::OUT_TDATA_W;
    localparam int AVG_MAX      = 16;     // MAX_SAMPLES of the instance
    localparam int READING_MAX  = 4095;
    localparam int GAP_MAX      = 13;
    localparam int DRAIN_CYCLES = 20;     // idle wait once every predicted result is out
    localparam int PHASE_ITEMS  = 150;
    localparam int PHASES       = 12;
    localparam int CYCLE_LIMIT  = 500000;

    typedef struct packed {
        logic             axis;
        logic [POS_W-1:0] position;
        logic             rejected;
    } t_touch_result;

    // ---------------------------------------------------------------
    // DUT hookup; every input has a known value from time zero
    // ---------------------------------------------------------------
    logic                    i_clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    s_valid = 1'b0;
    logic [IN_W-1:0]         s_data = '0;      // [11:0] sample
    logic [USR_W-1:0]        s_user = '0;      // [0] axis, [1] restart
    logic                    m_ready = 1'b0;
    logic                    cfg_we = 1'b0;
    logic [IDX_W-1:0]        cfg_idx = tsm_pkg::CFG_REJECT_X;
    logic [DAT_W-1:0]        cfg_data = '0;

    wire                     o_s_axis_tready;
    wire                     o_m_axis_tvalid;
    wire [OUT_W-1:0]         o_m_axis_tdata;   // [11:0] position
    wire [USR_W-1:0]         o_m_axis_tuser;   // [0] axis_out, [1] rejected

    touch_sample_trimmed_mean_unit uut (
        .i_clk           (i_clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tuser  (s_user),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .i_cfg_we        (cfg_we),
        .i_cfg_idx       (cfg_idx),
        .i_cfg_wdata     (cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // ---------------------------------------------------------------
    // Predictor state: shadow registers and the measurement in progress
    // ---------------------------------------------------------------
    logic [REJ_W-1:0]        thr_x = tsm_pkg::REJECT_RESET;
    logic [REJ_W-1:0]        thr_y = tsm_pkg::REJECT_RESET;
    logic [CNT_W-1:0]        avg_count = tsm_pkg::COUNT_RESET;

    tsm_pkg::t_phase         meas_stage = tsm_pkg::PH_DISCARD;
    logic                    meas_axis = 1'b0;
    logic [POS_W-1:0]        chk_first = '0;
    int unsigned             acc_sum = 0;
    int unsigned             acc_taken = 0;
    logic [POS_W-1:0]        acc_min = '1;
    logic [POS_W-1:0]        acc_max = '0;

    t_touch_result           due_results[$];
    int unsigned             sent_items = 0;
    int unsigned             mismatches = 0;
    int unsigned             cycle_count = 0;
    bit                      src_calm = 1'b0;   // 1: source never idles
    bit                      sink_calm = 1'b0;  // 1: sink never stalls
    int                      sink_hold = 0;

    function automatic int draw_gap(input bit calm);
        if (calm)
            return 0;
        return int'($urandom_range(0, GAP_MAX));
    endfunction

    // zero count means one; anything past the instance maximum is clamped
    function automatic int unsigned averaging_depth(input logic [CNT_W-1:0] c);
        if (c == '0)
            return 1;
        if (32'(c) > AVG_MAX)
            return AVG_MAX;
        return 32'(c);
    endfunction

    function automatic logic [POS_W-1:0] clamp_reading(input int v);
        if (v < 0)
            return '0;
        if (v > READING_MAX)
            return POS_W'(READING_MAX);
        return POS_W'(v);
    endfunction

    function automatic void clear_accumulator();
        acc_sum   = 0;
        acc_taken = 0;
        acc_min   = '1;
        acc_max   = '0;
    endfunction

    // Advance the measurement by one accepted sample; queue a result if one ends.
    function automatic void predict_position(input logic [POS_W-1:0] smp,
                                             input logic ax, input logic rs);
        logic [REJ_W-1:0] lim;
        logic [POS_W-1:0] gap;
        int unsigned      depth;
        int unsigned      total;
        int unsigned      divisor;
        t_touch_result    r;
        if (rs || meas_stage == tsm_pkg::PH_DISCARD) begin
            // discarded sample; axis latched here and held for the measurement
            meas_axis = ax;
            clear_accumulator();
            meas_stage = tsm_pkg::PH_CHECK1;
        end else if (meas_stage == tsm_pkg::PH_CHECK1) begin
            chk_first  = smp;
            meas_stage = tsm_pkg::PH_CHECK2;
        end else if (meas_stage == tsm_pkg::PH_CHECK2) begin
            lim = meas_axis ? thr_y : thr_x;
            gap = (chk_first > smp) ? chk_first - smp : smp - chk_first;
            if (gap > lim) begin
                r.axis     = meas_axis;
                r.position = '0;
                r.rejected = 1'b1;
                due_results.push_back(r);
                meas_stage = tsm_pkg::PH_DISCARD;
            end else begin
                clear_accumulator();
                meas_stage = tsm_pkg::PH_ACCUM;
            end
        end else begin
            acc_sum += 32'(smp);
            if (smp < acc_min)
                acc_min = smp;
            if (smp > acc_max)
                acc_max = smp;
            acc_taken++;
            // count in force right now decides when the run is complete
            depth = averaging_depth(avg_count);
            if (acc_taken >= depth) begin
                total   = acc_sum;
                divisor = depth;
                if (depth > 32'(tsm_pkg::TRIM_MIN_COUNT)) begin
                    total   = total - 32'(acc_min) - 32'(acc_max);
                    divisor = depth - 32'(tsm_pkg::TRIM_DROP);
                end
                r.axis     = meas_axis;
                r.position = POS_W'(total / divisor);
                r.rejected = 1'b0;
                due_results.push_back(r);
                meas_stage = tsm_pkg::PH_DISCARD;
                clear_accumulator();
            end
        end
    endfunction

    // ---------------------------------------------------------------
    // Source side: one input transaction per call
    // ---------------------------------------------------------------
    task automatic send_sample(input logic [POS_W-1:0] smp, input logic ax,
                               input logic rs);
        int gap;
        gap = draw_gap(src_calm);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_valid <= 1'b1;
        s_data  <= {{(IN_W - POS_W){1'b0}}, smp};
        s_user  <= {rs, ax};
        do
            @(posedge i_clk);
        while (!o_s_axis_tready);
        sent_items++;
        predict_position(smp, ax, rs);
    endtask

    // wait until every queued result is out, then wait out the DRAIN_CYCLES idle stretch
    task automatic wait_idle();
        while (due_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx, input int unsigned val);
        s_valid <= 1'b0;
        wait_idle();
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= DAT_W'(val);
        @(posedge i_clk);
        cfg_we <= 1'b0;
        case (idx)
            tsm_pkg::CFG_REJECT_X: thr_x = REJ_W'(val);
            tsm_pkg::CFG_REJECT_Y: thr_y = REJ_W'(val);
            tsm_pkg::CFG_COUNT:    avg_count = CNT_W'(val);
            default: ;
        endcase
    endtask

    // ---------------------------------------------------------------
    // Sink side: random stall after every result transaction
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin : sink_side
        int g;
        if (!rst_n) begin
            m_ready   <= 1'b0;
            sink_hold <= 0;
        end else if (m_ready && o_m_axis_tvalid) begin
            g = draw_gap(sink_calm);
            sink_hold <= g;
            m_ready   <= (g == 0);
        end else if (sink_hold > 0) begin
            sink_hold <= sink_hold - 1;
            m_ready   <= (sink_hold == 1);
        end else begin
            m_ready <= 1'b1;
        end
    end

    // compare each result transaction against the oldest prediction
    always @(posedge i_clk) begin : result_check
        t_touch_result want;
        if (rst_n && o_m_axis_tvalid && m_ready) begin
            if (due_results.size() == 0) begin
                $error("unexpected result: axis_out %0d position %0d rejected %0d",
                       o_m_axis_tuser[tsm_pkg::TUSER_AXIS], o_m_axis_tdata[POS_W-1:0],
                       o_m_axis_tuser[tsm_pkg::TUSER_REJECT]);
                mismatches++;
            end else begin
                want = due_results.pop_front();
                if (o_m_axis_tuser[tsm_pkg::TUSER_AXIS] !== want.axis) begin
                    $error("axis_out: expected %0d, got %0d", want.axis,
                           o_m_axis_tuser[tsm_pkg::TUSER_AXIS]);
                    mismatches++;
                end
                if (o_m_axis_tdata[POS_W-1:0] !== want.position) begin
                    $error("position: expected %0d, got %0d", want.position,
                           o_m_axis_tdata[POS_W-1:0]);
                    mismatches++;
                end
                if (o_m_axis_tuser[tsm_pkg::TUSER_REJECT] !== want.rejected) begin
                    $error("rejected: expected %0d, got %0d", want.rejected,
                           o_m_axis_tuser[tsm_pkg::TUSER_REJECT]);
                    mismatches++;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------

    // Reset defaults: count 4 with trimming, check gap exactly at the limit,
    // extreme readings as the trimmed min and max.
    task automatic test_default_measurement();
        send_sample(12'd100, 1'b0, 1'b1);
        send_sample(12'd0, 1'b1, 1'b0);
        send_sample(12'd16, 1'b0, 1'b0);
        send_sample(12'd4095, 1'b1, 1'b0);
        send_sample(12'd0, 1'b0, 1'b0);
        send_sample(12'd100, 1'b0, 1'b0);
        send_sample(12'd200, 1'b1, 1'b0);
    endtask

    // y-axis check samples one past the limit
    task automatic test_check_rejection();
        send_sample(12'd7, 1'b1, 1'b0);
        send_sample(12'd4095, 1'b1, 1'b0);
        send_sample(12'd4078, 1'b0, 1'b0);
    endtask

    // Restart drops a partial run, axis flips after the discard are ignored,
    // and a count lowered mid-run closes the run on the next sample.
    task automatic test_restart_and_count_change();
        send_sample(12'd1, 1'b0, 1'b0);
        send_sample(12'd5, 1'b0, 1'b0);
        send_sample(12'd5, 1'b0, 1'b0);
        send_sample(12'd10, 1'b0, 1'b0);
        send_sample(12'd9, 1'b1, 1'b1);
        send_sample(12'd7, 1'b0, 1'b0);
        send_sample(12'd7, 1'b0, 1'b0);
        send_sample(12'd1, 1'b0, 1'b0);
        write_reg(tsm_pkg::CFG_COUNT, 0);
        send_sample(12'd2, 1'b0, 1'b0);
    endtask

    // short bursts of unstructured samples, restarts included
    task automatic send_noise();
        int n;
        n = int'($urandom_range(1, 4));
        repeat (n)
            send_sample(POS_W'($urandom_range(0, READING_MAX)), 1'($urandom_range(0, 1)),
                        ($urandom_range(0, 3) == 0));
    endtask

    // One well-formed measurement with random content; now and then the
    // check pair is pushed over the limit or the run is cut short.
    task automatic send_measurement();
        int          spreads [3] = '{3, 64, 4095};
        int          first;
        int          d;
        int          lim;
        int          base;
        int          spread;
        int          cut;
        logic        rs;
        logic [POS_W-1:0] smp;
        rs = (meas_stage == tsm_pkg::PH_DISCARD) ? 1'($urandom_range(0, 1)) : 1'b1;
        send_sample(POS_W'($urandom_range(0, READING_MAX)), 1'($urandom_range(0, 1)), rs);
        lim   = meas_axis ? int'(thr_y) : int'(thr_x);
        first = int'($urandom_range(0, READING_MAX));
        case ($urandom_range(0, 7))
            5:       d = lim;
            6:       d = lim + 1;
            7:       d = int'($urandom_range(0, READING_MAX));
            default: d = int'($urandom_range(0, lim));
        endcase
        send_sample(POS_W'(first), 1'($urandom_range(0, 1)), 1'b0);
        if ($urandom_range(0, 1) && first + d <= READING_MAX)
            smp = POS_W'(first + d);
        else if (first >= d)
            smp = POS_W'(first - d);
        else
            smp = clamp_reading(first + d);
        send_sample(smp, 1'($urandom_range(0, 1)), 1'b0);
        if (meas_stage != tsm_pkg::PH_ACCUM)
            return;
        cut = int'(averaging_depth(avg_count));
        if ($urandom_range(0, 9) == 0)
            cut = int'($urandom_range(0, cut - 1));
        base   = int'($urandom_range(0, READING_MAX));
        spread = spreads[$urandom_range(0, 2)];
        repeat (cut) begin
            case ($urandom_range(0, 9))
                0:       smp = POS_W'($urandom_range(0, READING_MAX));
                1:       smp = $urandom_range(0, 1) ? POS_W'(READING_MAX) : '0;
                default: smp = clamp_reading(base + int'($urandom_range(0, 2 * spread))
                                             - spread);
            endcase
            send_sample(smp, 1'($urandom_range(0, 1)), 1'b0);
        end
    endtask

    // Several register settings, extremes first, then random ones; the
    // last phase writes a count above the instance maximum.
    task automatic test_random_settings();
        int unsigned preset_x [7] = '{16, 0, 4095, 0, 4095, 8, 30};
        int unsigned preset_y [7] = '{16, 0, 4095, 4095, 0, 40, 2};
        int unsigned preset_n [7] = '{4, 1, 16, 0, 2, 3, 5};
        int unsigned px;
        int unsigned py;
        int unsigned pn;
        int unsigned phase_end;
        int          p;
        for (p = 0; p < PHASES; p++) begin
            if (p < 7) begin
                px = preset_x[p];
                py = preset_y[p];
                pn = preset_n[p];
            end else begin
                px = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4095)
                                                 : $urandom_range(0, 64);
                py = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4095)
                                                 : $urandom_range(0, 64);
                pn = (p == PHASES - 1) ? 31 : $urandom_range(0, AVG_MAX);
            end
            write_reg(tsm_pkg::CFG_REJECT_X, px);
            write_reg(tsm_pkg::CFG_REJECT_Y, py);
            write_reg(tsm_pkg::CFG_COUNT, pn);
            src_calm  = ($urandom_range(0, 3) == 0);
            sink_calm = ($urandom_range(0, 3) == 0);
            phase_end = sent_items + PHASE_ITEMS;
            while (sent_items < phase_end) begin
                if ($urandom_range(0, 19) == 0)
                    send_noise();
                else
                    send_measurement();
            end
        end
    endtask

    task automatic finish_run();
        s_valid <= 1'b0;
        wait_idle();
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    endtask

    // ---------------------------------------------------------------
    // Sequence
    // ---------------------------------------------------------------
    initial begin
        repeat (8) @(posedge i_clk);
        rst_n <= 1'b1;
        @(posedge i_clk);
        test_default_measurement();
        test_check_rejection();
        test_restart_and_count_change();
        test_random_settings();
        finish_run();
    end

    // watchdog: a stuck handshake or a missing result ends here
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("== FAIL ==");
        $finish;
    end

endmodule
